// ===== src/nsr_pkg.sv =====
// ============================================================================
// nsr_pkg
// Shared types and constants for the Newton-Raphson square root unit.
// ============================================================================
package nsr_pkg;

    // Default fixed-point format and step limit
    localparam int FRAC_BITS_DEF = 16;
    localparam int INT_BITS_DEF  = 24;
    localparam int MAX_STEPS_DEF = 64;

    // Fixed port widths
    localparam int VAL_W  = 40;
    localparam int STEP_W = 7;
    localparam int TOL_W  = 20;

    localparam logic [TOL_W-1:0] TOL_RESET = 20'd6554;

    // Partial product selector for the split square
    typedef enum logic [1:0] {
        PP_LL = 2'd0,
        PP_LH = 2'd1,
        PP_HH = 2'd2
    } pp_phase_t;

    // Controller -> datapath
    typedef struct packed {
        logic      load;
        logic      mul_issue;
        pp_phase_t mul_phase;
        logic      mul_acc;
        logic      sub;
        logic      abs_en;
        logic      div_init;
        logic      div_step;
        logic      update;
        logic      out_load;
        logic      conv;
    } nsr_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic err_ok;
        logic steps_max;
        logic out_free;
    } nsr_status_t;

endpackage

// ===== src/nsr_ctrl.sv =====
// ============================================================================
// nsr_ctrl
// Sequencer: square, error check, serial divide and update per Newton step.
// ============================================================================
module nsr_ctrl #(
    parameter int FRAC_BITS = nsr_pkg::FRAC_BITS_DEF,
    parameter int INT_BITS  = nsr_pkg::INT_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  nsr_pkg::nsr_status_t status,
    output nsr_pkg::nsr_cmd_t    cmd
);

    localparam int W  = INT_BITS + FRAC_BITS;
    localparam int CW = $clog2(2 * W);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MUL   = 8'b0000_0010,
        S_SUB   = 8'b0000_0100,
        S_ABS   = 8'b0000_1000,
        S_CHECK = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_UPD   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          conv_reg, conv_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            conv_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            conv_reg  <= conv_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.conv   = conv_reg;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        conv_next  = conv_reg;

        case (cnt_reg[1:0])
            2'd0:    cmd.mul_phase = nsr_pkg::PP_LL;
            2'd1:    cmd.mul_phase = nsr_pkg::PP_LH;
            default: cmd.mul_phase = nsr_pkg::PP_HH;
        endcase

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                // issue on counts 0..2, accumulate on counts 1..3
                cmd.mul_issue = (cnt_reg != CW'(3));
                cmd.mul_acc   = (cnt_reg != '0);
                if (cnt_reg == CW'(3))
                begin
                    cnt_next   = '0;
                    state_next = S_SUB;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            S_SUB:
            begin
                cmd.sub    = 1'b1;
                state_next = S_ABS;
            end
            S_ABS:
            begin
                cmd.abs_en = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (status.err_ok)
                begin
                    conv_next  = 1'b1;
                    state_next = S_DONE;
                end
                else if (status.steps_max)
                begin
                    conv_next  = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CW'(2 * W - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_UPD;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                cnt_next   = '0;
                state_next = S_MUL;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/nsr_dp.sv =====
// ============================================================================
// nsr_dp
// Datapath: estimate, split squarer, error magnitude, restoring divider,
// tolerance register and output register.
// ============================================================================
module nsr_dp #(
    parameter int FRAC_BITS = nsr_pkg::FRAC_BITS_DEF,
    parameter int INT_BITS  = nsr_pkg::INT_BITS_DEF,
    parameter int MAX_STEPS = nsr_pkg::MAX_STEPS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  nsr_pkg::nsr_cmd_t           cmd,
    output nsr_pkg::nsr_status_t        status,
    input  logic [nsr_pkg::VAL_W-1:0]   value,
    input  logic                        tolerance_we,
    input  logic [nsr_pkg::TOL_W-1:0]   tolerance_wdata,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [nsr_pkg::VAL_W-1:0]   root,
    output logic [nsr_pkg::STEP_W-1:0]  step_count,
    output logic                        converged
);

    localparam int W    = INT_BITS + FRAC_BITS;
    localparam int L    = (W + 1) / 2;
    localparam int EW   = 2 * W - FRAC_BITS;
    localparam int PONE = ((1 << FRAC_BITS) + 5) / 10;   // 0.1 rounded
    localparam int XW   = nsr_pkg::VAL_W + W;

    logic [nsr_pkg::TOL_W-1:0]  tol_reg;
    logic [W-1:0]               x_reg;
    logic [W-1:0]               v_reg;
    logic [2*L-1:0]             prod_reg;
    nsr_pkg::pp_phase_t         pp_phase_reg;
    logic [2*W-1:0]             sq_reg;
    logic [2*W:0]               sd_reg;
    logic                       neg_reg;
    logic [2*W-1:0]             dvd_reg;     // |x*x - v|, then quotient
    logic [W:0]                 rem_reg;
    logic [nsr_pkg::STEP_W-1:0] steps_reg;
    logic                       out_valid_reg;
    logic [nsr_pkg::VAL_W-1:0]  root_reg;
    logic [nsr_pkg::STEP_W-1:0] step_out_reg;
    logic                       conv_out_reg;

    // input trim / output fit
    logic [XW-1:0] val_ext, root_ext;
    logic [W-1:0]  v_in, x_init;

    assign val_ext  = XW'(value);
    assign v_in     = val_ext[W-1:0];
    assign x_init   = (v_in > W'(PONE)) ? v_in : W'(PONE);
    assign root_ext = XW'(x_reg);

    // split squarer, one L x L product per cycle
    logic [L-1:0]   x_lo, x_hi, op_a, op_b;
    logic [2*L-1:0] prod;
    logic [2*W-1:0] pp_term, sq_base;

    assign x_lo = x_reg[L-1:0];
    assign x_hi = L'(x_reg[W-1:L]);

    always_comb
    begin
        case (cmd.mul_phase)
            nsr_pkg::PP_LL:
            begin
                op_a = x_lo;
                op_b = x_lo;
            end
            nsr_pkg::PP_LH:
            begin
                op_a = x_lo;
                op_b = x_hi;
            end
            default:
            begin
                op_a = x_hi;
                op_b = x_hi;
            end
        endcase
    end

    assign prod = {{L{1'b0}}, op_a} * {{L{1'b0}}, op_b};

    always_comb
    begin
        case (pp_phase_reg)
            nsr_pkg::PP_LL: pp_term = (2*W)'(prod_reg);
            nsr_pkg::PP_LH: pp_term = (2*W)'(prod_reg) << (L + 1);   // cross term twice
            default:        pp_term = (2*W)'(prod_reg) << (2 * L);
        endcase
        sq_base = (pp_phase_reg == nsr_pkg::PP_LL) ? '0 : sq_reg;
    end

    // error and its magnitude
    logic [2*W:0]   sd_next;
    logic [2*W-1:0] sd_neg;

    assign sd_next = {1'b0, sq_reg} - ((2*W+1)'(v_reg) << FRAC_BITS);
    assign sd_neg  = ~sd_reg[2*W-1:0] + (2*W)'(1);

    // restoring divide step, divisor 2x
    logic [W+1:0] rem_sh, dvs, rem_diff;
    logic         q_bit;

    assign rem_sh   = {rem_reg, dvd_reg[2*W-1]};
    assign dvs      = {1'b0, x_reg, 1'b0};
    assign q_bit    = (rem_sh >= dvs);
    assign rem_diff = rem_sh - dvs;

    // x update with saturation / floor at one ulp
    logic         q_hi;
    logic [W-1:0] q_lo;
    logic [W:0]   x_sum, x_dif;
    logic [W-1:0] x_upd;

    assign q_hi  = |dvd_reg[2*W-1:W];
    assign q_lo  = dvd_reg[W-1:0];
    assign x_sum = {1'b0, x_reg} + {1'b0, q_lo};
    assign x_dif = {1'b0, x_reg} - {1'b0, q_lo};

    always_comb
    begin
        if (neg_reg)
        begin
            x_upd = (q_hi || x_sum[W]) ? {W{1'b1}} : x_sum[W-1:0];
        end
        else
        begin
            x_upd = (q_hi || x_dif[W] || (x_dif[W-1:0] == '0)) ? W'(1) : x_dif[W-1:0];
        end
    end

    // status
    assign status.err_ok    = (dvd_reg[2*W-1:FRAC_BITS] <= EW'(tol_reg));
    assign status.steps_max = (steps_reg >= nsr_pkg::STEP_W'(MAX_STEPS));
    assign status.out_free  = !out_valid_reg || out_ready;

    // control-bearing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg       <= nsr_pkg::TOL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (tolerance_we)
            begin
                tol_reg <= tolerance_wdata;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            v_reg     <= v_in;
            x_reg     <= x_init;
            steps_reg <= '0;
        end
        if (cmd.mul_issue)
        begin
            prod_reg     <= prod;
            pp_phase_reg <= cmd.mul_phase;
        end
        if (cmd.mul_acc)
        begin
            sq_reg <= sq_base + pp_term;
        end
        if (cmd.sub)
        begin
            sd_reg <= sd_next;
        end
        if (cmd.abs_en)
        begin
            neg_reg <= sd_reg[2*W];
            dvd_reg <= sd_reg[2*W] ? sd_neg : sd_reg[2*W-1:0];
        end
        if (cmd.div_init)
        begin
            rem_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= q_bit ? rem_diff[W:0] : rem_sh[W:0];
            dvd_reg <= {dvd_reg[2*W-2:0], q_bit};
        end
        if (cmd.update)
        begin
            x_reg     <= x_upd;
            steps_reg <= steps_reg + nsr_pkg::STEP_W'(1);
        end
        if (cmd.out_load)
        begin
            root_reg     <= root_ext[nsr_pkg::VAL_W-1:0];
            step_out_reg <= steps_reg;
            conv_out_reg <= cmd.conv;
        end
    end

    assign out_valid  = out_valid_reg;
    assign root       = root_reg;
    assign step_count = step_out_reg;
    assign converged  = conv_out_reg;

endmodule

// ===== src/newton_square_root_unit.sv =====
// ============================================================================
// newton_square_root_unit
// Newton-Raphson square root of an unsigned Q(INT_BITS).(FRAC_BITS) value.
// ============================================================================
// One radicand beat in, one result beat out (Q24.16 by default). The
// estimate starts at max(value, 0.1), and each Newton step runs the split
// squarer (three half-width partial products through one multiplier), the
// signed error and its magnitude, the tolerance check, the bit-serial
// restoring divider that forms (x*x - value) / 2x, and the update, in that
// order. Items are handled one at a time; a new radicand is taken while the
// previous result still waits in the output register. The tolerance
// register (reset 6554, i.e. 0.1 in Q.16) is written through tolerance_we /
// tolerance_wdata; the user must write it only while the unit is idle, as the
// block itself does not enforce this.
// ============================================================================
module newton_square_root_unit #(
    parameter int FRAC_BITS = nsr_pkg::FRAC_BITS_DEF,
    parameter int INT_BITS  = nsr_pkg::INT_BITS_DEF,
    parameter int MAX_STEPS = nsr_pkg::MAX_STEPS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // radicand beat
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [nsr_pkg::VAL_W-1:0]   value,
    // result beat
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [nsr_pkg::VAL_W-1:0]   root,
    output logic [nsr_pkg::STEP_W-1:0]  step_count,
    output logic                        converged,
    // tolerance register write
    input  logic                        tolerance_we,
    input  logic [nsr_pkg::TOL_W-1:0]   tolerance_wdata
);

    nsr_pkg::nsr_cmd_t    cmd;
    nsr_pkg::nsr_status_t status;

    // sequencer: one-hot FSM stepping squarer, check, divider, update
    nsr_ctrl #(
        .FRAC_BITS (FRAC_BITS),
        .INT_BITS  (INT_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic and result register
    nsr_dp #(
        .FRAC_BITS (FRAC_BITS),
        .INT_BITS  (INT_BITS),
        .MAX_STEPS (MAX_STEPS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .value           (value),
        .tolerance_we    (tolerance_we),
        .tolerance_wdata (tolerance_wdata),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .root            (root),
        .step_count      (step_count),
        .converged       (converged)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Self-checking bench for the Newton-Raphson square root unit: random and
// corner radicands under several tolerance settings, each result checked
// against an in-bench model of the iteration.
// ============================================================================
module testbench;

    // Port widths and reset tolerance of the unit
    localparam int VAL_W  = nsr_pkg::VAL_W;
    localparam int STEP_W = nsr_pkg::STEP_W;
    localparam int TOL_W  = nsr_pkg::TOL_W;
    localparam logic [TOL_W-1:0] TOL_RESET = nsr_pkg::TOL_RESET;

    // Format of the instance under test (package defaults)
    localparam int FRAC_BITS = nsr_pkg::FRAC_BITS_DEF;
    localparam int W         = nsr_pkg::INT_BITS_DEF + nsr_pkg::FRAC_BITS_DEF;
    localparam int MAX_STEPS = nsr_pkg::MAX_STEPS_DEF;
    // 0.1 rounded to the nearest Q.FRAC_BITS code
    localparam int unsigned POINT_ONE = ((1 << FRAC_BITS) + 5) / 10;

    localparam logic [TOL_W-1:0] TOL_MAX   = {TOL_W{1'b1}};
    localparam logic [TOL_W-1:0] TOL_MIN   = TOL_W'(1);
    localparam logic [TOL_W-1:0] TOL_EXACT = '0;

    // Worst single item: every step (square, error, serial divide, update)
    // plus the final test, rounded up.
    localparam int ITEM_CYCLES    = MAX_STEPS * (2 * W + 8) + 400;
    localparam int HOLD_CYCLES    = 8000;
    localparam int WATCHDOG_LIMIT = 4 * (ITEM_CYCLES + HOLD_CYCLES);
    localparam int HOLD_AFTER     = 330;

    // Corners run at the reset tolerance: zero, one ulp, both sides of 0.1,
    // values below 1.0, exact squares, full scale and bit patterns.
    localparam int N_CORNERS = 22;
    localparam logic [VAL_W-1:0] CORNER_VALUES [N_CORNERS] = '{
        40'h00_0000_0000, 40'h00_0000_0001, 40'h00_0000_1999, 40'h00_0000_199A,
        40'h00_0000_199B, 40'h00_0000_4000, 40'h00_0000_FFFF, 40'h00_0001_0000,
        40'h00_0002_0000, 40'h00_0002_4000, 40'h00_0004_0000, 40'h00_0064_0000,
        40'h00_FFFF_0000, 40'hFF_FFFF_0000, 40'hFF_FFFF_FFFF, 40'h80_0000_0000,
        40'hAA_AAAA_AAAA, 40'h55_5555_5555, 40'h00_0000_8000, 40'h01_0000_0000,
        40'h7F_FFFF_FFFF, 40'h00_0009_0000
    };

    typedef struct {
        logic [VAL_W-1:0]  root;
        logic [STEP_W-1:0] steps;
        logic              conv;
    } root_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: runs the iteration on each accepted radicand and keeps the
    // expected results in order; each result beat is checked against the
    // oldest one.
    // ------------------------------------------------------------------------
    class root_checker;
        logic [TOL_W-1:0] tolerance = TOL_RESET;
        root_result_t     expected_roots [$];
        int unsigned      accepted;
        int unsigned      checked;
        int unsigned      errors;
        int unsigned      step_limited;

        function automatic root_result_t newton_root(logic [VAL_W-1:0] radicand);
            logic [127:0] full_scale, v, x, vs, sq, diff, err, quot;
            logic         below;
            int unsigned  steps;
            root_result_t r;
            full_scale = (128'd1 << W) - 1;
            v = 128'(radicand) & full_scale;
            x = (v > POINT_ONE) ? v : 128'(POINT_ONE);
            vs = v << FRAC_BITS;
            steps = 0;
            r.conv = 1'b0;
            while (1'b1)
            begin
                sq = x * x;
                below = sq < vs;
                diff = below ? vs - sq : sq - vs;
                err = diff >> FRAC_BITS;
                if (err <= 128'(tolerance))
                begin
                    r.conv = 1'b1;
                    break;
                end
                // error is tested once more after the last allowed step
                if (steps >= MAX_STEPS)
                    break;
                quot = diff / (x << 1);
                if (below)
                    x = (quot > full_scale - x) ? full_scale : x + quot;  // saturate
                else
                    x = (quot >= x) ? 128'd1 : x - quot;                  // floor at 1 ulp
                steps++;
            end
            r.root = x[VAL_W-1:0];
            r.steps = STEP_W'(steps);
            return r;
        endfunction

        function void note_radicand(logic [VAL_W-1:0] radicand);
            expected_roots.push_back(newton_root(radicand));
            accepted++;
        endfunction

        function void check_root(logic [VAL_W-1:0] root, logic [STEP_W-1:0] steps,
                                 logic conv);
            root_result_t exp_r;
            if (expected_roots.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with nothing expected: root %h steps %0d conv %b",
                         $time, root, steps, conv);
                return;
            end
            exp_r = expected_roots.pop_front();
            checked++;
            if (!exp_r.conv)
                step_limited++;
            if (root !== exp_r.root)
            begin
                errors++;
                $display("%0t: root mismatch: expected %h, got %h",
                         $time, exp_r.root, root);
            end
            if (steps !== exp_r.steps)
            begin
                errors++;
                $display("%0t: step_count mismatch: expected %0d, got %0d",
                         $time, exp_r.steps, steps);
            end
            if (conv !== exp_r.conv)
            begin
                errors++;
                $display("%0t: converged mismatch: expected %b, got %b",
                         $time, exp_r.conv, conv);
            end
        endfunction

        function int unsigned pending();
            return expected_roots.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [VAL_W-1:0]  value;
    logic              out_valid;
    logic              out_ready;
    logic [VAL_W-1:0]  root;
    logic [STEP_W-1:0] step_count;
    logic              converged;
    logic              tolerance_we;
    logic [TOL_W-1:0]  tolerance_wdata;

    root_checker chk = new;

    // Set while both sides run flat out (no idle cycles at all)
    bit          calm = 1'b0;
    int unsigned tol_settings = 1;   // the reset value counts as the first

    newton_square_root_unit u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .value           (value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .root            (root),
        .step_count      (step_count),
        .converged       (converged),
        .tolerance_we    (tolerance_we),
        .tolerance_wdata (tolerance_wdata)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Radicand generator. The wide mode spreads over the whole range; the
    // tight mode is for very low tolerances, where most items run to the step
    // limit, so it keeps roots small and leans on exact squares.
    // ------------------------------------------------------------------------
    function automatic logic [VAL_W-1:0] pick_radicand(input bit tight);
        logic [63:0] raw;
        int unsigned k;
        int unsigned sel;
        raw = {$urandom, $urandom};
        k = $urandom_range(4095, 1);
        sel = $urandom_range(99);
        if (tight)
        begin
            if (sel < 60)
                return VAL_W'(raw[17:0]);                 // below 4.0
            if (sel < 85)
                return VAL_W'(k * k) << FRAC_BITS;        // exact square
            return raw[VAL_W-1:0];
        end
        if (sel < 35)
            return raw[VAL_W-1:0];                        // full 40-bit range
        if (sel < 60)
            return VAL_W'(raw[23:0]);                     // below 256.0
        if (sel < 78)
            return VAL_W'(raw[15:0]);                     // below 1.0
        if (sel < 88)
            return VAL_W'($urandom_range(POINT_ONE + 16, POINT_ONE - 16)); // near 0.1
        return VAL_W'(k * k) << FRAC_BITS;
    endfunction

    // One radicand beat. Idle cycles go in front of valid; once valid is up
    // it stays with the same value until the unit takes it.
    task automatic send_radicand(input logic [VAL_W-1:0] v);
        while (!calm && $urandom_range(99) < 27)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        do
            @(posedge clk);
        while (!in_ready);
        chk.note_radicand(v);
    endtask

    // Drop valid and wait until every expected result has been taken; the
    // unit computes one item at a time, so it is idle after that.
    task automatic wait_all_roots();
        in_valid <= 1'b0;
        while (chk.pending() != 0)
            @(posedge clk);
    endtask

    // Tolerance write: one cycle with the write enable up, only while idle
    task automatic set_tolerance(input logic [TOL_W-1:0] t);
        tolerance_we    <= 1'b1;
        tolerance_wdata <= t;
        @(posedge clk);
        tolerance_we <= 1'b0;
        chk.tolerance = t;
        tol_settings++;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random back-pressure, one long hold-off partway through so
    // the result register fills and the input stalls, and no idling while
    // the calm flag is set.
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        bit held_off;
        int unsigned hold_count;
        held_off = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held_off && chk.checked >= HOLD_AFTER)
            begin
                held_off = 1'b1;
                out_ready <= 1'b0;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
                    @(posedge clk);
            end
            out_ready <= calm || ($urandom_range(99) >= 27);
        end
    end

    // Result monitor: sample at the edge, before the unit's own updates land
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            chk.check_root(root, step_count, converged);
    end

    // Watchdog: a long run of cycles with no beat on either side means a hang
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int i;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        value           = '0;
        tolerance_we    = 1'b0;
        tolerance_wdata = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corners at the reset tolerance (0.1)
        for (i = 0; i < N_CORNERS; i++)
            send_radicand(CORNER_VALUES[i]);
        wait_all_roots();

        // Loosest tolerance: few steps, wide random values
        set_tolerance(TOL_MAX);
        for (i = 0; i < 200; i++)
            send_radicand(pick_radicand(1'b0));
        wait_all_roots();

        // Tightest nonzero tolerance: many items run to the step limit
        set_tolerance(TOL_MIN);
        for (i = 0; i < 40; i++)
            send_radicand(pick_radicand(1'b1));
        wait_all_roots();

        // Zero tolerance: an item converges only when x*x is within one ulp of the
        // radicand. Zero radicand walks the 0.1 guess down toward one ulp.
        set_tolerance(TOL_EXACT);
        send_radicand('0);
        send_radicand(VAL_W'(4) << FRAC_BITS);
        send_radicand(VAL_W'(9) << FRAC_BITS);
        for (i = 0; i < 10; i++)
            send_radicand(pick_radicand(1'b1));
        wait_all_roots();

        // Random tolerance; the receiver's long hold-off lands in here
        set_tolerance(TOL_W'($urandom_range(TOL_MAX, 8192)));
        for (i = 0; i < 250; i++)
            send_radicand(pick_radicand(1'b0));
        wait_all_roots();

        // Back to 0.1 written explicitly; first stretch runs with no idling
        set_tolerance(TOL_RESET);
        calm = 1'b1;
        for (i = 0; i < 230; i++)
        begin
            if (i == 120)
                calm = 1'b0;
            send_radicand(pick_radicand(1'b0));
        end
        wait_all_roots();

        // Let a stray result show up if the unit would produce one
        repeat (ITEM_CYCLES) @(posedge clk);

        $display("Covered %0d radicands under %0d tolerance settings (reset, max, 1, 0, random)",
                 chk.accepted, tol_settings);
        $display("%0d results checked, %0d at the step limit, %0d mismatches",
                 chk.checked, chk.step_limited, chk.errors);
        if (chk.errors == 0 && chk.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
src/nsr_pkg.sv
src/nsr_ctrl.sv
src/nsr_dp.sv
src/newton_square_root_unit.sv
tb/testbench.sv
